// ===== rtl/psu_pkg.sv =====
// Package with shared types, register map and character codes for the sample unpacker.
package psu_pkg;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [1:0] REG_SAMPLE_BITS  = 2'd0;
   localparam logic [1:0] REG_MSB_FIRST    = 2'd1;
   localparam logic [1:0] REG_ASCII_MODE   = 2'd2;
   localparam logic [1:0] REG_LINE_SAMPLES = 2'd3;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   typedef struct packed {
      logic [4:0]  sample_bits;
      logic        msb_first;
      logic        ascii_mode;
      logic [15:0] line_samples;
   } psu_cfg_type;

   typedef struct packed {
      logic load_byte;
      logic ascii_step;
      logic merge;
      logic extract;
      logic extract_last;
   } psu_cmd_type;

   typedef struct packed {
      logic ascii_mode;
      logic width_ok;
      logic can_extract;
      logic more_after;
      logic at_end;
      logic stage_free;
   } psu_status_type;

   // Returns 255 * ceil(2^24 / (2^bits - 1)); the top byte of v times this gives v*255/m.
   function automatic logic [31:0] scale_const(input logic [3:0] bits);
      logic [31:0] k;
      case (bits)
         4'd1:    k = 32'd4278190080;
         4'd2:    k = 32'd1426063530;
         4'd3:    k = 32'd611170230;
         4'd4:    k = 32'd285212910;
         4'd5:    k = 32'd138006255;
         4'd6:    k = 32'd67908030;
         4'd7:    k = 32'd33686775;
         4'd8:    k = 32'd16777470;
         default: k = 32'd0;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/psu_if.sv =====
// Handshake interfaces for the byte input channel and the sample result channel.
interface psu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface psu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample;
   logic       end_of_line;
   logic       error;
   logic       last;

   modport source (output valid, output sample, output end_of_line, output error,
                   output last, input ready);
   modport sink (input valid, input sample, input end_of_line, input error,
                 input last, output ready);
endinterface

// ===== rtl/packed_sample_unpacker_unit.sv =====
// Top level of the packed sample unpacker: register bank, controller and datapath.
//
//   Channel    Direction  Carries
//   req_chan   in         one file byte per word (in_byte)
//   rsp_chan   out        one 8-bit sample per word with end_of_line, error, last
//   csr_*      in/out     APB-style access to sample_bits, msb_first, ascii_mode,
//                         line_samples
//
// A binary byte is loaded, merged into the bit buffer and then yields k samples
// (k up to 8), one sample per cycle while the scaling stage is free; a text byte
// is loaded and then decoded. Each sample passes a scaling stage and the result
// register before it appears; the next byte is taken while results drain.
// Reset is synchronous; it restores state, config and valid flags, not data.
// A stalled result channel holds extraction once the scaling stage is full.
module packed_sample_unpacker_unit
   import psu_pkg::*;
#(
   parameter int LINE_COUNT_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   psu_req_if.sink                   req_chan,
   psu_rsp_if.source                 rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   psu_cfg_type    cfg;
   psu_cmd_type    cmd;
   psu_status_type status;

   psu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   psu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   psu_dp #(
      .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .in_byte         (req_chan.in_byte),
      .status          (status),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_sample      (rsp_chan.sample),
      .rsp_end_of_line (rsp_chan.end_of_line),
      .rsp_error       (rsp_chan.error),
      .rsp_last        (rsp_chan.last)
   );

endmodule

// ===== rtl/psu_csr.sv =====
// Configuration register bank behind the APB-style port.
module psu_csr
   import psu_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output psu_cfg_type               cfg
);

   psu_cfg_type cfg_ff;
   psu_cfg_type cfg_in;
   logic        write_en;
   logic [1:0]  reg_index;

   assign write_en  = psel & penable & pwrite;
   assign reg_index = paddr[3:2];
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_SAMPLE_BITS:  cfg_in.sample_bits  = pwdata[4:0];
            REG_MSB_FIRST:    cfg_in.msb_first    = pwdata[0];
            REG_ASCII_MODE:   cfg_in.ascii_mode   = pwdata[0];
            REG_LINE_SAMPLES: cfg_in.line_samples = pwdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_SAMPLE_BITS:  prdata = CSR_DATA_WIDTH'(cfg_ff.sample_bits);
         REG_MSB_FIRST:    prdata = CSR_DATA_WIDTH'(cfg_ff.msb_first);
         REG_ASCII_MODE:   prdata = CSR_DATA_WIDTH'(cfg_ff.ascii_mode);
         REG_LINE_SAMPLES: prdata = CSR_DATA_WIDTH'(cfg_ff.line_samples);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_bits  <= 5'd8;
         cfg_ff.msb_first    <= 1'b1;
         cfg_ff.ascii_mode   <= 1'b0;
         cfg_ff.line_samples <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/psu_ctrl.sv =====
// Controller state machine that sequences byte intake, decoding and sample extraction.
module psu_ctrl
   import psu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  psu_status_type status,
   output psu_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UNPACK
   } state_type;

   state_type  state_ff;
   logic [2:0] count_ff;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_byte = req_valid;
         end
         ST_DECODE: begin
            if (status.ascii_mode) begin
               cmd.ascii_step = status.stage_free;
            end else begin
               cmd.merge = status.width_ok;
            end
         end
         ST_UNPACK: begin
            cmd.extract      = status.can_extract & status.stage_free;
            cmd.extract_last = !status.more_after || (count_ff == 3'd7) || status.at_end;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               count_ff <= '0;
               if (status.ascii_mode) begin
                  if (status.stage_free) begin
                     state_ff <= ST_IDLE;
                  end
               end else if (status.width_ok) begin
                  state_ff <= ST_UNPACK;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_UNPACK: begin
               if (!status.can_extract) begin
                  state_ff <= ST_IDLE;
               end else if (status.stage_free) begin
                  if (cmd.extract_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     count_ff <= count_ff + 3'd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/psu_dp.sv =====
// Datapath with bit buffer, text parser, line counter, scaling stage and result register.
module psu_dp
   import psu_pkg::*;
#(
   parameter int LINE_COUNT_WIDTH = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  psu_cfg_type    cfg,
   input  psu_cmd_type    cmd,
   input  logic [7:0]     in_byte,
   output psu_status_type status,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output logic [7:0]     rsp_sample,
   output logic           rsp_end_of_line,
   output logic           rsp_error,
   output logic           rsp_last
);

   localparam logic [1:0] PH_LEAD   = 2'd0;
   localparam logic [1:0] PH_DIGITS = 2'd1;
   localparam logic [1:0] PH_TRAIL  = 2'd2;

   logic [7:0]                  byte_ff;
   logic [15:0]                 buf_ff, buf_in;
   logic [4:0]                  held_ff, held_in;
   logic [LINE_COUNT_WIDTH-1:0] idx_ff, idx_in;
   logic [1:0]                  phase_ff, phase_in;
   logic [15:0]                 dec_ff, dec_in;

   logic       s1_valid_ff;
   logic       s1_load;
   logic       s1_direct_ff, s1_direct_in;
   logic [7:0] s1_value_ff, s1_value_in;
   logic       s1_eol_ff, s1_eol_in;
   logic       s1_err_ff, s1_err_in;
   logic       s1_last_ff, s1_last_in;

   logic       rsp_valid_ff;
   logic [7:0] rsp_sample_ff;
   logic       rsp_eol_ff;
   logic       rsp_err_ff;
   logic       rsp_last_ff;
   logic       out_load;
   logic [39:0] product;

   logic [4:0]                  bits;
   logic                        msb;
   logic [7:0]                  mask8;
   logic [4:0]                  held_after;
   logic [15:0]                 msb_shift;
   logic [15:0]                 keep_mask;
   logic [7:0]                  msb_val;
   logic [7:0]                  lsb_val;
   logic [LINE_COUNT_WIDTH-1:0] line_len;
   logic [LINE_COUNT_WIDTH-1:0] idx_plus;
   logic                        at_end;
   logic [LINE_COUNT_WIDTH-1:0] idx_next;
   logic                        is_digit;
   logic                        is_blank;
   logic                        is_space;
   logic [7:0]                  digit;
   logic [15:0]                 dec_x10;
   logic [7:0]                  ascii_val;
   logic [7:0]                  expect_char;
   logic                        delim;

   assign bits       = cfg.sample_bits;
   assign msb        = (bits == 5'd1) || cfg.msb_first;
   assign mask8      = 8'hFF >> (4'd8 - bits[3:0]);
   assign held_after = held_ff - bits;
   assign msb_shift  = buf_ff >> held_after;
   assign keep_mask  = (16'd1 << held_after) - 16'd1;
   assign msb_val    = msb_shift[7:0] & mask8;
   assign lsb_val    = buf_ff[7:0] & mask8;

   assign line_len = LINE_COUNT_WIDTH'(cfg.line_samples);
   assign idx_plus = idx_ff + LINE_COUNT_WIDTH'(1);
   assign at_end   = (idx_plus == line_len);
   assign idx_next = at_end ? '0 : idx_plus;

   assign is_digit    = (byte_ff >= CHAR_ZERO) && (byte_ff <= CHAR_NINE);
   assign is_space    = (byte_ff == CHAR_SPACE) || (byte_ff == CHAR_TAB);
   assign is_blank    = is_space || (byte_ff == CHAR_CR) || (byte_ff == CHAR_LF);
   assign digit       = byte_ff - CHAR_ZERO;
   assign dec_x10     = {dec_ff[12:0], 3'b000} + {dec_ff[14:0], 1'b0};
   assign expect_char = at_end ? CHAR_CR : CHAR_COMMA;

   always_comb begin
      case (bits)
         5'd1:    ascii_val = (dec_ff != 16'd0) ? 8'hFF : 8'h00;
         5'd8:    ascii_val = dec_ff[7:0];
         5'd16:   ascii_val = dec_ff[15:8];
         default: ascii_val = 8'h00;
      endcase
   end

   always_comb begin
      case (phase_ff)
         PH_LEAD:   delim = !is_blank && !is_digit;
         PH_DIGITS: delim = !is_digit && !is_space;
         default:   delim = !is_space;
      endcase
   end

   assign out_load = s1_valid_ff && (!rsp_valid_ff || rsp_ready);

   assign status.ascii_mode  = cfg.ascii_mode;
   assign status.width_ok    = (bits >= 5'd1) && (bits <= 5'd8);
   assign status.can_extract = (held_ff >= bits);
   assign status.more_after  = (held_after >= bits);
   assign status.at_end      = at_end;
   assign status.stage_free  = !s1_valid_ff || out_load;

   always_comb begin
      buf_in       = buf_ff;
      held_in      = held_ff;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      dec_in       = dec_ff;
      s1_load      = 1'b0;
      s1_direct_in = s1_direct_ff;
      s1_value_in  = s1_value_ff;
      s1_eol_in    = s1_eol_ff;
      s1_err_in    = s1_err_ff;
      s1_last_in   = s1_last_ff;

      if (cmd.merge) begin
         if (msb) begin
            buf_in = {buf_ff[7:0], byte_ff};
         end else begin
            buf_in = buf_ff | (16'(byte_ff) << held_ff[2:0]);
         end
         held_in = held_ff + 5'd8;
      end

      if (cmd.extract) begin
         s1_load      = 1'b1;
         s1_direct_in = 1'b0;
         s1_value_in  = msb ? msb_val : lsb_val;
         s1_eol_in    = at_end;
         s1_err_in    = 1'b0;
         s1_last_in   = cmd.extract_last;
         idx_in       = idx_next;
         if (at_end) begin
            buf_in  = '0;
            held_in = '0;
         end else begin
            held_in = held_after;
            buf_in  = msb ? (buf_ff & keep_mask) : (buf_ff >> bits);
         end
      end

      if (cmd.ascii_step) begin
         case (phase_ff)
            PH_LEAD: begin
               if (is_digit) begin
                  dec_in   = 16'(digit);
                  phase_in = PH_DIGITS;
               end
            end
            PH_DIGITS: begin
               if (is_digit) begin
                  dec_in = dec_x10 + 16'(digit);
               end else if (is_space) begin
                  phase_in = PH_TRAIL;
               end
            end
            default: phase_in = phase_ff;
         endcase
         if (delim) begin
            phase_in     = PH_LEAD;
            dec_in       = '0;
            s1_load      = 1'b1;
            s1_direct_in = 1'b1;
            s1_last_in   = 1'b1;
            if (byte_ff == expect_char) begin
               s1_value_in = ascii_val;
               s1_eol_in   = at_end;
               s1_err_in   = 1'b0;
               idx_in      = idx_next;
            end else begin
               s1_value_in = 8'h00;
               s1_eol_in   = 1'b1;
               s1_err_in   = 1'b1;
               idx_in      = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         held_ff      <= '0;
         idx_ff       <= '0;
         phase_ff     <= PH_LEAD;
         dec_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff   <= buf_in;
         held_ff  <= held_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
         dec_ff   <= dec_in;
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (out_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign product = s1_value_ff * scale_const(bits[3:0]);

   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         byte_ff <= in_byte;
      end
      s1_direct_ff <= s1_direct_in;
      s1_value_ff  <= s1_value_in;
      s1_eol_ff    <= s1_eol_in;
      s1_err_ff    <= s1_err_in;
      s1_last_ff   <= s1_last_in;
      if (out_load) begin
         rsp_sample_ff <= s1_direct_ff ? s1_value_ff : product[31:24];
         rsp_eol_ff    <= s1_eol_ff;
         rsp_err_ff    <= s1_err_ff;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_end_of_line = rsp_eol_ff;
   assign rsp_error       = rsp_err_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the packed sample unpacker: directed and random byte streams.
`timescale 1ns / 100ps

module testbench;
   import psu_pkg::*;

   localparam int IDLE_PCT    = 13;
   localparam int SETTLE      = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_CAP   = 100;

   typedef struct packed {
      logic [7:0] sample;
      logic       end_of_line;
      logic       error;
      logic       last;
   } sample_word_type;

   typedef enum logic [1:0] {PHASE_LEAD, PHASE_DIGITS, PHASE_TRAIL} text_phase_type;

   logic clock = 1'b0;
   logic reset;

   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   psu_req_if req_chan ();
   psu_rsp_if rsp_chan ();

   packed_sample_unpacker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Predictor copy of the registers and the unpacking state.
   logic [4:0]     cfg_bits;
   logic           cfg_msb;
   logic           cfg_ascii;
   logic [15:0]    cfg_line;
   logic [15:0]    bit_store;
   int unsigned    held;
   logic [15:0]    line_pos;
   text_phase_type text_phase;
   logic [15:0]    dec_value;

   sample_word_type expected_samples[$];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  bytes_sent = 0;
   logic sender_idle_on = 1'b1;
   logic receiver_idle_on = 1'b1;
   logic [7:0] blanks [4] = '{CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};

   function automatic logic line_ends_here();
      return (line_pos + 16'd1) == cfg_line;
   endfunction

   function automatic logic advance_line();
      if (line_ends_here()) begin
         line_pos = '0;
         return 1'b1;
      end
      line_pos = line_pos + 16'd1;
      return 1'b0;
   endfunction

   task automatic predict_samples(input logic [7:0] c);
      int unsigned     bits, m, v, n;
      logic            msb, eol, is_space, is_blank, is_digit;
      logic [7:0]      delim, s;
      sample_word_type prev;
      logic            have_prev;
      if (cfg_ascii) begin
         is_space = (c == CHAR_SPACE) || (c == CHAR_TAB);
         is_blank = is_space || (c == CHAR_CR) || (c == CHAR_LF);
         is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
         case (text_phase)
            PHASE_LEAD: begin
               if (is_blank) return;
               if (is_digit) begin
                  dec_value = 16'(c - CHAR_ZERO);
                  text_phase = PHASE_DIGITS;
                  return;
               end
            end
            PHASE_DIGITS: begin
               if (is_digit) begin
                  dec_value = dec_value * 16'd10 + 16'(c - CHAR_ZERO);
                  return;
               end
               if (is_space) begin
                  text_phase = PHASE_TRAIL;
                  return;
               end
            end
            default: begin
               if (is_space) return;
            end
         endcase
         delim = line_ends_here() ? CHAR_CR : CHAR_COMMA;
         if (c != delim) begin
            line_pos = '0;
            text_phase = PHASE_LEAD;
            dec_value = '0;
            expected_samples.push_back('{sample: 8'd0, end_of_line: 1'b1, error: 1'b1,
                                         last: 1'b1});
            return;
         end
         case (cfg_bits)
            5'd1:    s = (dec_value != 16'd0) ? 8'hff : 8'h00;
            5'd8:    s = dec_value[7:0];
            5'd16:   s = dec_value[15:8];
            default: s = 8'h00;
         endcase
         eol = advance_line();
         text_phase = PHASE_LEAD;
         dec_value = '0;
         expected_samples.push_back('{sample: s, end_of_line: eol, error: 1'b0, last: 1'b1});
      end else begin
         bits = cfg_bits;
         if (bits < 1 || bits > 8) return;
         msb = (bits == 1) || cfg_msb;
         m = (1 << bits) - 1;
         if (msb)
            bit_store = {bit_store[7:0], c};
         else
            bit_store = bit_store | (16'(c) << (held & 7));
         held += 8;
         n = 0;
         have_prev = 1'b0;
         while (held >= bits && n < 8) begin
            if (msb) begin
               v = (bit_store >> (held - bits)) & m;
               held -= bits;
               bit_store &= 16'((1 << held) - 1);
            end else begin
               v = bit_store & m;
               bit_store >>= bits;
               held -= bits;
            end
            eol = advance_line();
            if (have_prev) expected_samples.push_back(prev);
            prev = '{sample: 8'((v * 255) / m), end_of_line: eol, error: 1'b0, last: 1'b0};
            have_prev = 1'b1;
            n++;
            if (eol) begin
               bit_store = '0;
               held = 0;
               break;
            end
         end
         if (have_prev) begin
            prev.last = 1'b1;
            expected_samples.push_back(prev);
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic send_byte(input logic [7:0] b);
      while (sender_idle_on && ($urandom_range(99) < IDLE_PCT)) begin
         req_chan.valid <= 1'b0;
         req_chan.in_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.in_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
      predict_samples(b);
   endtask

   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_samples.size() != 0);
   endtask

   task automatic wait_idle();
      hold_until_drained();
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         REG_SAMPLE_BITS:  cfg_bits = value[4:0];
         REG_MSB_FIRST:    cfg_msb = value[0];
         REG_ASCII_MODE:   cfg_ascii = value[0];
         REG_LINE_SAMPLES: cfg_line = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [4:0] bits, input logic msb, input logic ascii,
                                 input logic [15:0] line);
      wait_idle();
      write_register(REG_SAMPLE_BITS, 32'(bits));
      write_register(REG_MSB_FIRST, 32'(msb));
      write_register(REG_ASCII_MODE, 32'(ascii));
      write_register(REG_LINE_SAMPLES, 32'(line));
   endtask

   task automatic test_binary_basics();
      apply_settings(5'd8, 1'b1, 1'b0, 16'd1);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'ha5);
      // One-bit samples ignore the bit order setting.
      apply_settings(5'd1, 1'b0, 1'b0, 16'd8);
      send_byte(8'h96);
      // The line ends inside the second byte, so its remaining bits are dropped.
      apply_settings(5'd3, 1'b0, 1'b0, 16'd4);
      send_byte(8'hff);
      send_byte(8'h00);
      send_byte(8'h5a);
      apply_settings(5'd16, 1'b1, 1'b0, 16'd3);
      send_byte(8'h12);
   endtask

   task automatic test_text_basics();
      apply_settings(5'd16, 1'b1, 1'b1, 16'd2);
      send_byte("7");
      send_byte(CHAR_COMMA);
      send_byte("6");
      send_byte("5");
      send_byte("5");
      send_byte("3");
      send_byte("5");
      send_byte(CHAR_CR);
      // A bad delimiter aborts the line.
      apply_settings(5'd8, 1'b1, 1'b1, 16'd3);
      send_byte("9");
      send_byte("x");
      apply_settings(5'd1, 1'b1, 1'b1, 16'd1);
      send_byte(CHAR_LF);
      send_byte("0");
      send_byte(CHAR_CR);
   endtask

   task automatic test_zero_line_length();
      apply_settings(5'd8, 1'b1, 1'b0, 16'd0);
      send_byte(8'h00);
      send_byte(8'hff);
   endtask

   task automatic test_random_binary();
      logic [4:0]  bits;
      logic [15:0] line;
      int          target;
      for (int p = 0; p < 7; p++) begin
         case (p)
            0:       bits = 5'd1;
            1:       bits = 5'd8;
            6:       bits = ($urandom_range(1) != 0) ? 5'd0 : 5'($urandom_range(9, 31));
            default: bits = 5'($urandom_range(1, 8));
         endcase
         line = (p == 2) ? 16'hffff : 16'($urandom_range(1, 12));
         apply_settings(bits, 1'($urandom), 1'b0, line);
         sender_idle_on = (p != 3);
         receiver_idle_on = (p != 3);
         target = bytes_sent + ((p == 6) ? 10 : 35);
         while (bytes_sent < target) begin
            if ($urandom_range(49) == 0) hold_until_drained();
            send_byte(8'($urandom));
         end
         sender_idle_on = 1'b1;
         receiver_idle_on = 1'b1;
      end
   endtask

   task automatic test_random_text();
      logic [4:0]  bits;
      logic [15:0] line;
      int          target;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       bits = 5'd1;
            1:       bits = 5'd16;
            4:       bits = 5'($urandom_range(2, 7));
            default: bits = ($urandom_range(1) != 0) ? 5'd8 : 5'd16;
         endcase
         line = (p == 2) ? 16'hffff : 16'($urandom_range(1, 6));
         apply_settings(bits, 1'($urandom), 1'b1, line);
         sender_idle_on = (p != 3);
         receiver_idle_on = (p != 3);
         target = bytes_sent + 35;
         while (bytes_sent < target) begin
            if ($urandom_range(49) == 0) hold_until_drained();
            if ($urandom_range(99) < 8) begin
               send_byte(8'($urandom));
            end else begin
               repeat ($urandom_range(2)) send_byte(blanks[$urandom_range(3)]);
               repeat ($urandom_range(6)) send_byte(8'(CHAR_ZERO + $urandom_range(9)));
               repeat ($urandom_range(1)) send_byte(blanks[$urandom_range(1)]);
               if ($urandom_range(9) == 0)
                  send_byte(line_ends_here() ? CHAR_COMMA : CHAR_CR);
               else
                  send_byte(line_ends_here() ? CHAR_CR : CHAR_COMMA);
            end
         end
         sender_idle_on = 1'b1;
         receiver_idle_on = 1'b1;
      end
   endtask

   always @(posedge clock) begin : result_check
      sample_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("word with sample %0d arrived with nothing expected",
                                      rsp_chan.sample));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_chan.sample !== want.sample)
               report_mismatch($sformatf("sample got %0d, expected %0d",
                                         rsp_chan.sample, want.sample));
            if (rsp_chan.end_of_line !== want.end_of_line)
               report_mismatch($sformatf("end_of_line got %b, expected %b",
                                         rsp_chan.end_of_line, want.end_of_line));
            if (rsp_chan.error !== want.error)
               report_mismatch($sformatf("error got %b, expected %b",
                                         rsp_chan.error, want.error));
            if (rsp_chan.last !== want.last)
               report_mismatch($sformatf("last got %b, expected %b",
                                         rsp_chan.last, want.last));
         end
      end
      rsp_chan.ready <= !(receiver_idle_on && ($urandom_range(99) < IDLE_PCT));
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("packed_sample_unpacker_unit verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.in_byte = 8'h00;
      rsp_chan.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_bits = 5'd8;
      cfg_msb = 1'b1;
      cfg_ascii = 1'b0;
      cfg_line = 16'd1;
      bit_store = '0;
      held = 0;
      line_pos = '0;
      text_phase = PHASE_LEAD;
      dec_value = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_binary_basics();
      test_text_basics();
      test_zero_line_length();
      test_random_binary();
      test_random_text();
      wait_idle();
      if (mismatch_count == 0 && expected_samples.size() == 0)
         $display("packed_sample_unpacker_unit verification clean");
      else
         $display("packed_sample_unpacker_unit verification failed");
      $finish;
   end

endmodule
